FILE: src/bdy_pkg.sv
package bdy_pkg;

  localparam int unsigned POOL_BYTES  = 65536;
  localparam int unsigned GRAIN_ORDER = 5;
  localparam int unsigned NGRAN       = POOL_BYTES >> GRAIN_ORDER;
  localparam int unsigned GW          = $clog2(NGRAN);
  localparam int unsigned LW          = GW + 1;
  localparam int unsigned TOP_ORDER   = $clog2(POOL_BYTES);
  localparam int unsigned NORD        = TOP_ORDER - GRAIN_ORDER + 1;
  localparam int unsigned HEAD_BYTES  = 16;
  localparam int unsigned MARK_W      = 18;

  localparam logic [LW-1:0] NIL = LW'(NGRAN);

  typedef logic [2:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_ZERO     = 3'd1;
  localparam status_t ST_LARGE    = 3'd2;
  localparam status_t ST_NOSPACE  = 3'd3;
  localparam status_t ST_BADMARK  = 3'd4;
  localparam status_t ST_RANGE    = 3'd5;
  localparam status_t ST_BADORDER = 3'd6;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

endpackage

FILE: src/bdy_if.sv
interface bdy_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] req_size;
  logic [16:0] alignment;
  logic [15:0] free_offset;

  modport source(output valid, kind, req_size, alignment, free_offset, input ready);
  modport sink(input valid, kind, req_size, alignment, free_offset, output ready);
endinterface

interface bdy_out_if;
  logic              valid;
  logic              ready;
  bdy_pkg::status_t  status;
  logic [15:0]       user_offset;
  logic [15:0]       block_offset;
  logic [4:0]        block_order;
  logic [16:0]       bytes_in_use;
  logic [16:0]       free_bytes;

  modport source(output valid, status, user_offset, block_offset, block_order, bytes_in_use,
                 free_bytes, input ready);
  modport sink(input valid, status, user_offset, block_offset, block_order, bytes_in_use,
               free_bytes, output ready);
endinterface

FILE: src/bdy_ram.sv
module bdy_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/buddy_allocator.sv
// Buddy allocator over a 64 KiB pool of 32-byte granules.
// Input channel in_bus carries one request per beat: kind selects allocate or
// free, with req_size and alignment for allocate and free_offset for free.
// Output channel out_bus returns exactly one result beat per request: status,
// user and block offsets, block order and the used and free byte counts.
// A request is taken only while the sequencer is idle; it then runs alone.
// A successful allocate runs alignment rounding, order search and list search,
// which step one order per cycle, then splits, each split pushing one block.
// A zero size or a bad free offset skips the search and goes straight to the
// done state. Free reads the prefix mark, then the block order, then looks for
// the buddy in the free list of its order, walking one entry at a time; on a
// hit it merges and moves up an order, and at last it pushes the merged block.
// The link memory has one read port. The result sits in an output register; if
// the receiver stalls, the next request may still be accepted, and its result
// waits until that register empties. After reset the block clears the prefix
// mark and link memories, one entry a cycle over all 2048 entries, and accepts
// no request until then.
module buddy_allocator (
  input  logic       clk,
  input  logic       rst_n,
  bdy_in_if.sink     in_bus,
  bdy_out_if.source  out_bus
);

  localparam int unsigned GW = bdy_pkg::GW;
  localparam int unsigned LW = bdy_pkg::LW;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_ALIGN  = 14'b00000000000100,
    S_WANT   = 14'b00000000001000,
    S_FIND   = 14'b00000000010000,
    S_POP    = 14'b00000000100000,
    S_SPLIT  = 14'b00000001000000,
    S_FMARK  = 14'b00000010000000,
    S_FORD   = 14'b00000100000000,
    S_FSTART = 14'b00001000000000,
    S_FWALK  = 14'b00010000000000,
    S_FWNXT  = 14'b00100000000000,
    S_FPUSH  = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0] head_r [bdy_pkg::NORD];
  logic [LW-1:0] head_nxt [bdy_pkg::NORD];
  logic [GW-1:0] clr_r, clr_nxt;
  logic [31:0] size_r, size_nxt;
  logic [16:0] align_r, align_nxt;
  logic [15:0] fo_r, fo_nxt;
  logic [17:0] p_r, p_nxt;
  logic [33:0] need_r, need_nxt;
  logic [4:0] o_r, o_nxt, want_r, want_nxt;
  logic [GW-1:0] g_r, g_nxt, bud_r, bud_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [11:0] n_r, n_nxt;
  logic [16:0] used_r, used_nxt;
  bdy_pkg::status_t st_r, st_nxt;
  logic [15:0] ru_r, ru_nxt, rb_r, rb_nxt;
  logic [4:0] ro_r, ro_nxt;
  logic out_valid_r, out_valid_nxt;
  bdy_pkg::status_t os_r;
  logic [15:0] ou_r, ob_r;
  logic [4:0] oo_r;
  logic [16:0] oused_r;

  logic nl_we, ao_we, pm_we;
  logic [GW-1:0] nl_waddr, nl_raddr, ao_waddr, ao_raddr, pm_waddr, pm_raddr;
  logic [LW-1:0] nl_wdata, nl_rdata;
  logic [4:0] ao_wdata, ao_rdata;
  logic [bdy_pkg::MARK_W-1:0] pm_wdata, pm_rdata;

  logic [4:0] hord, o_dn;
  logic [3:0] hidx;
  logic hok;
  logic [LW-1:0] head_rd;
  logic [33:0] need_sum;
  logic [GW-1:0] half;
  logic [17:0] ublk;
  logic [16:0] off, fo17, diff, osz;
  logic in_fire;
  logic load_out;

  bdy_ram #(.W(LW), .D(bdy_pkg::NGRAN)) u_link (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata), .raddr(nl_raddr),
    .rdata(nl_rdata)
  );

  bdy_ram #(.W(5), .D(bdy_pkg::NGRAN)) u_order (
    .clk(clk), .we(ao_we), .waddr(ao_waddr), .wdata(ao_wdata), .raddr(ao_raddr),
    .rdata(ao_rdata)
  );

  bdy_ram #(.W(bdy_pkg::MARK_W), .D(bdy_pkg::NGRAN)) u_mark (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata), .raddr(pm_raddr),
    .rdata(pm_rdata)
  );

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign load_out     = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  assign o_dn     = o_r - 5'd1;
  assign hord     = (state_r == S_SPLIT) ? o_dn : o_r;
  assign hok      = (hord >= 5'(bdy_pkg::GRAIN_ORDER)) && (hord <= 5'(bdy_pkg::TOP_ORDER));
  assign hidx     = 4'(hord - 5'(bdy_pkg::GRAIN_ORDER));
  assign head_rd  = hok ? head_r[hidx] : bdy_pkg::NIL;
  assign need_sum = {2'b00, size_r} + 34'(bdy_pkg::HEAD_BYTES) + {16'd0, p_r} + 34'd31;
  assign half     = GW'(1) << (o_dn - 5'(bdy_pkg::GRAIN_ORDER));
  assign ublk     = {2'b00, g_r, 5'd0} + p_r;
  assign off      = pm_rdata[16:0];
  assign fo17     = {1'b0, fo_r};
  assign diff     = fo17 - off;
  assign osz      = 17'(1) << ao_rdata;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    clr_nxt       = clr_r;
    size_nxt      = size_r;
    align_nxt     = align_r;
    fo_nxt        = fo_r;
    p_nxt         = p_r;
    need_nxt      = need_r;
    o_nxt         = o_r;
    want_nxt      = want_r;
    g_nxt         = g_r;
    bud_nxt       = bud_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    n_nxt         = n_r;
    used_nxt      = used_r;
    st_nxt        = st_r;
    ru_nxt        = ru_r;
    rb_nxt        = rb_r;
    ro_nxt        = ro_r;
    nl_we         = 1'b0;
    nl_waddr      = g_r;
    nl_wdata      = head_rd;
    nl_raddr      = cur_r[GW-1:0];
    ao_we         = 1'b0;
    ao_waddr      = g_r;
    ao_wdata      = o_r;
    ao_raddr      = diff[15:5];
    pm_we         = 1'b0;
    pm_waddr      = fo_r[15:5];
    pm_wdata      = '0;
    pm_raddr      = in_bus.free_offset[15:5];
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_r;
        nl_we    = 1'b1;
        nl_waddr = clr_r;
        nl_wdata = bdy_pkg::NIL;
        clr_nxt  = clr_r + GW'(1);
        if (clr_r == GW'(bdy_pkg::NGRAN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          size_nxt  = in_bus.req_size;
          align_nxt = in_bus.alignment;
          fo_nxt    = in_bus.free_offset;
          ru_nxt    = '0;
          rb_nxt    = '0;
          ro_nxt    = '0;
          st_nxt    = bdy_pkg::ST_OK;
          if (in_bus.kind == bdy_pkg::KIND_ALLOC) begin
            p_nxt = 18'd32;
            if (in_bus.req_size == '0) begin
              st_nxt    = bdy_pkg::ST_ZERO;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ALIGN;
            end
          end else if (in_bus.free_offset[4:0] != 5'd0) begin
            st_nxt    = bdy_pkg::ST_BADMARK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FMARK;
          end
        end
      end
      S_ALIGN: begin
        if (p_r < {1'b0, align_r}) begin
          p_nxt = p_r << 1;
        end else begin
          need_nxt  = {need_sum[33:5], 5'd0};
          o_nxt     = 5'(bdy_pkg::GRAIN_ORDER);
          state_nxt = S_WANT;
        end
      end
      S_WANT: begin
        if (o_r < 5'(bdy_pkg::TOP_ORDER) && (34'(1) << o_r) < need_r) begin
          o_nxt = o_r + 5'd1;
        end else if ((34'(1) << o_r) < need_r) begin
          st_nxt    = bdy_pkg::ST_LARGE;
          state_nxt = S_DONE;
        end else begin
          want_nxt  = o_r;
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (o_r > 5'(bdy_pkg::TOP_ORDER)) begin
          st_nxt    = bdy_pkg::ST_NOSPACE;
          state_nxt = S_DONE;
        end else if (head_rd[GW]) begin
          o_nxt = o_r + 5'd1;
        end else begin
          g_nxt     = head_rd[GW-1:0];
          nl_raddr  = head_rd[GW-1:0];
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        head_nxt[hidx] = nl_rdata;
        state_nxt      = S_SPLIT;
      end
      S_SPLIT: begin
        if (o_r > want_r) begin
          nl_we          = 1'b1;
          nl_waddr       = g_r + half;
          nl_wdata       = head_rd;
          head_nxt[hidx] = {1'b0, g_r + half};
          o_nxt          = o_dn;
        end else begin
          ao_we  = 1'b1;
          ao_wdata = o_r;
          if (ublk[17:16] == 2'b00) begin
            pm_we    = 1'b1;
            pm_waddr = ublk[15:5];
            pm_wdata = {1'b1, p_r[16:0]};
          end
          used_nxt  = used_r + (17'(1) << o_r);
          rb_nxt    = {g_r, 5'd0};
          ru_nxt    = ublk[15:0];
          ro_nxt    = o_r;
          state_nxt = S_DONE;
        end
      end
      S_FMARK: begin
        g_nxt = diff[15:5];
        if (!pm_rdata[bdy_pkg::MARK_W-1]) begin
          st_nxt    = bdy_pkg::ST_BADMARK;
          state_nxt = S_DONE;
        end else if (off > fo17) begin
          st_nxt    = bdy_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FORD;
        end
      end
      S_FORD: begin
        if (ao_rdata < 5'(bdy_pkg::GRAIN_ORDER) || ao_rdata > 5'(bdy_pkg::TOP_ORDER)) begin
          st_nxt    = bdy_pkg::ST_BADORDER;
          state_nxt = S_DONE;
        end else begin
          pm_we     = 1'b1;
          used_nxt  = (used_r >= osz) ? used_r - osz : '0;
          o_nxt     = ao_rdata;
          state_nxt = S_FSTART;
        end
      end
      S_FSTART: begin
        if (o_r < 5'(bdy_pkg::TOP_ORDER)) begin
          bud_nxt   = g_r ^ (GW'(1) << (o_r - 5'(bdy_pkg::GRAIN_ORDER)));
          cur_nxt   = head_rd;
          prev_nxt  = bdy_pkg::NIL;
          n_nxt     = '0;
          state_nxt = S_FWALK;
        end else begin
          state_nxt = S_FPUSH;
        end
      end
      S_FWALK: begin
        if (cur_r[GW] || n_r > 12'(bdy_pkg::NGRAN)) begin
          state_nxt = S_FPUSH;
        end else begin
          nl_raddr  = cur_r[GW-1:0];
          state_nxt = S_FWNXT;
        end
      end
      S_FWNXT: begin
        if (cur_r[GW-1:0] == bud_r) begin
          if (prev_r[GW]) begin
            head_nxt[hidx] = nl_rdata;
          end else begin
            nl_we    = 1'b1;
            nl_waddr = prev_r[GW-1:0];
            nl_wdata = nl_rdata;
          end
          if (bud_r < g_r) begin
            g_nxt = bud_r;
          end
          o_nxt     = o_r + 5'd1;
          state_nxt = S_FSTART;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = nl_rdata;
          n_nxt     = n_r + 12'd1;
          state_nxt = S_FWALK;
        end
      end
      S_FPUSH: begin
        nl_we          = 1'b1;
        nl_waddr       = g_r;
        nl_wdata       = head_rd;
        head_nxt[hidx] = {1'b0, g_r};
        rb_nxt         = {g_r, 5'd0};
        ro_nxt         = o_r;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < int'(bdy_pkg::NORD); i++) begin
        head_r[i] <= (i == int'(bdy_pkg::NORD) - 1) ? '0 : bdy_pkg::NIL;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    align_r <= align_nxt;
    fo_r    <= fo_nxt;
    p_r     <= p_nxt;
    need_r  <= need_nxt;
    o_r     <= o_nxt;
    want_r  <= want_nxt;
    g_r     <= g_nxt;
    bud_r   <= bud_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    n_r     <= n_nxt;
    st_r    <= st_nxt;
    ru_r    <= ru_nxt;
    rb_r    <= rb_nxt;
    ro_r    <= ro_nxt;
    if (load_out) begin
      os_r    <= st_r;
      ou_r    <= ru_r;
      ob_r    <= rb_r;
      oo_r    <= ro_r;
      oused_r <= used_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = os_r;
  assign out_bus.user_offset  = ou_r;
  assign out_bus.block_offset = ob_r;
  assign out_bus.block_order  = oo_r;
  assign out_bus.bytes_in_use = oused_r;
  assign out_bus.free_bytes   = 17'(bdy_pkg::POOL_BYTES) - oused_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= 17'(bdy_pkg::POOL_BYTES))
    else $error("used byte count exceeds the pool");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_bus.ready)
    else $error("sequencer ready again right after taking a request");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FWNXT |-> n_r <= 12'(bdy_pkg::NGRAN))
    else $error("free list walk ran past the granule count");

  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |-> o_r >= want_r)
    else $error("split went below the wanted order");
`endif

endmodule

FILE: tb/sv/buddy_allocator_test.sv
`timescale 1ns / 100ps

module buddy_allocator_test;

  localparam int GRAIN_ORDER = bdy_pkg::GRAIN_ORDER;
  localparam int NGRAN = bdy_pkg::NGRAN;
  localparam int NORD = bdy_pkg::NORD;
  localparam int TOP_ORDER = bdy_pkg::TOP_ORDER;
  localparam int HEAD_BYTES = bdy_pkg::HEAD_BYTES;
  localparam int POOL_BYTES = bdy_pkg::POOL_BYTES;
  localparam int GRAIN_BYTES = 1 << GRAIN_ORDER;
  localparam int EMPTY = NGRAN;
  localparam int RANDOM_ITEMS = 1830;
  localparam int STALL_LIMIT = 300000;

  typedef struct packed {
    logic        kind;
    logic [31:0] req_size;
    logic [16:0] alignment;
    logic [15:0] free_offset;
  } request_t;

  typedef struct packed {
    bdy_pkg::status_t status;
    logic [15:0]      user_offset;
    logic [15:0]      block_offset;
    logic [4:0]       block_order;
    logic [16:0]      bytes_in_use;
    logic [16:0]      free_bytes;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bdy_in_if  in_bus();
  bdy_out_if out_bus();

  buddy_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow allocator state.
  int          free_head [NORD];
  int          free_link [NGRAN];
  int          blk_order [NGRAN];
  bit          mark_ok   [NGRAN];
  int          mark_dist [NGRAN];
  int unsigned used_total;

  request_t    pending_reqs [$];
  outcome_t    awaited_results [$];
  logic [15:0] live_offsets [$];
  logic [15:0] dead_offsets [$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  burst = 1'b0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void push_free(int o, int g);
    if (g >= NGRAN) return;
    free_link[g] = free_head[o - GRAIN_ORDER];
    free_head[o - GRAIN_ORDER] = g;
  endfunction

  function automatic bit take_free(int o, int g);
    int prev;
    int cur;
    int n;
    prev = EMPTY;
    cur = free_head[o - GRAIN_ORDER];
    n = 0;
    while (cur < NGRAN && n <= NGRAN) begin
      if (cur == g) begin
        if (prev == EMPTY) free_head[o - GRAIN_ORDER] = free_link[cur];
        else free_link[prev] = free_link[cur];
        return 1'b1;
      end
      prev = cur;
      cur = free_link[cur];
      n++;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t allocate_or_free(request_t rq);
    outcome_t r;
    longint unsigned need;
    longint unsigned p;
    int want;
    int o;
    int g;
    int ug;
    int off;
    int bud;
    int fo;
    r = '0;
    r.status = bdy_pkg::ST_OK;
    if (rq.kind == bdy_pkg::KIND_ALLOC) begin
      if (rq.req_size == 0) begin
        r.status = bdy_pkg::ST_ZERO;
      end else begin
        p = GRAIN_BYTES;
        while (p < rq.alignment) p = p << 1;
        need = longint'(rq.req_size) + HEAD_BYTES + p;
        need = (need + GRAIN_BYTES - 1) & ~longint'(GRAIN_BYTES - 1);
        want = GRAIN_ORDER;
        while (want < TOP_ORDER && (64'd1 << want) < need) want++;
        if ((64'd1 << want) < need) begin
          r.status = bdy_pkg::ST_LARGE;
        end else begin
          o = want;
          while (o <= TOP_ORDER && free_head[o - GRAIN_ORDER] >= NGRAN) o++;
          if (o > TOP_ORDER) begin
            r.status = bdy_pkg::ST_NOSPACE;
          end else begin
            g = free_head[o - GRAIN_ORDER];
            free_head[o - GRAIN_ORDER] = free_link[g];
            while (o > want) begin
              o--;
              push_free(o, g + (1 << (o - GRAIN_ORDER)));
            end
            blk_order[g] = o;
            r.block_offset = 16'(g << GRAIN_ORDER);
            r.user_offset = 16'((g << GRAIN_ORDER) + int'(p));
            ug = ((g << GRAIN_ORDER) + int'(p)) >> GRAIN_ORDER;
            if (ug < NGRAN) begin
              mark_ok[ug] = 1'b1;
              mark_dist[ug] = int'(p);
            end
            used_total += 1 << o;
            r.block_order = 5'(o);
          end
        end
      end
    end else begin
      fo = rq.free_offset;
      ug = fo >> GRAIN_ORDER;
      if (fo % GRAIN_BYTES != 0 || ug >= NGRAN || !mark_ok[ug]) begin
        r.status = bdy_pkg::ST_BADMARK;
      end else begin
        off = mark_dist[ug];
        if (off > fo || fo - off >= POOL_BYTES) begin
          r.status = bdy_pkg::ST_RANGE;
        end else begin
          g = (fo - off) >> GRAIN_ORDER;
          o = blk_order[g];
          if (o < GRAIN_ORDER || o > TOP_ORDER) begin
            r.status = bdy_pkg::ST_BADORDER;
          end else begin
            mark_ok[ug] = 1'b0;
            if (used_total >= (1 << o)) used_total -= 1 << o;
            else used_total = 0;
            while (o < TOP_ORDER) begin
              bud = g ^ (1 << (o - GRAIN_ORDER));
              if (!take_free(o, bud)) break;
              if (bud < g) g = bud;
              o++;
            end
            push_free(o, g);
            r.block_offset = 16'(g << GRAIN_ORDER);
            r.block_order = 5'(o);
          end
        end
      end
    end
    r.bytes_in_use = 17'(used_total);
    r.free_bytes = 17'(POOL_BYTES - used_total);
    return r;
  endfunction

  task automatic queue_item(logic kind, logic [31:0] sz, logic [16:0] al, logic [15:0] fo);
    request_t rq;
    outcome_t r;
    rq = '{kind, sz, al, fo};
    r = allocate_or_free(rq);
    pending_reqs.push_back(rq);
    awaited_results.push_back(r);
    if (kind == bdy_pkg::KIND_ALLOC && r.status == bdy_pkg::ST_OK)
      live_offsets.push_back(r.user_offset);
  endtask

  task automatic release_live(int idx);
    logic [15:0] fo;
    fo = live_offsets[idx];
    live_offsets.delete(idx);
    dead_offsets.push_back(fo);
    if (dead_offsets.size() > 8) void'(dead_offsets.pop_front());
    queue_item(bdy_pkg::KIND_FREE, $urandom, 17'($urandom), fo);
  endtask

  task automatic random_item();
    int pick;
    logic [16:0] al;
    logic [31:0] sz;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      al = (pick < 40) ? 17'(1 << $urandom_range(0, 9)) : 17'($urandom_range(0, 2048));
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20000) : $urandom_range(1, 1500);
      queue_item(bdy_pkg::KIND_ALLOC, sz, al, 16'($urandom));
    end else if (pick < 88 && live_offsets.size() > 0) begin
      release_live($urandom_range(0, live_offsets.size() - 1));
    end else if (pick < 92 && dead_offsets.size() > 0) begin
      queue_item(bdy_pkg::KIND_FREE, $urandom, 17'($urandom),
                 dead_offsets[$urandom_range(0, dead_offsets.size() - 1)]);
    end else if (pick < 96) begin
      queue_item(bdy_pkg::KIND_FREE, $urandom, 17'($urandom), 16'($urandom));
    end else begin
      sz = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom);
      queue_item(bdy_pkg::KIND_ALLOC, sz, 17'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.kind = bdy_pkg::KIND_ALLOC;
    in_bus.req_size = '0;
    in_bus.alignment = '0;
    in_bus.free_offset = '0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < NORD; i++) free_head[i] = EMPTY;
    for (int i = 0; i < NGRAN; i++) begin
      free_link[i] = EMPTY;
      blk_order[i] = 0;
      mark_ok[i] = 1'b0;
      mark_dist[i] = 0;
    end
    used_total = 0;
    push_free(TOP_ORDER, 0);

    queue_item(bdy_pkg::KIND_ALLOC, 32'd0, 17'd32, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 17'd0, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd1, 17'h1_0000, 16'd0);
    queue_item(bdy_pkg::KIND_FREE, 32'd0, 17'd0, 16'hFFFF);
    queue_item(bdy_pkg::KIND_FREE, 32'd0, 17'd0, 16'hFFE0);
    queue_item(bdy_pkg::KIND_FREE, 32'd0, 17'd0, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd65488, 17'd0, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd1, 17'd1, 16'd0);
    release_live(0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd1, 17'h0_8000, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd1, 17'd32, 16'd0);
    release_live(0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd1, 17'd0, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd100, 17'd33, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd5000, 17'd1000, 16'd0);
    queue_item(bdy_pkg::KIND_ALLOC, 32'd16, 17'd64, 16'd0);
    queue_item(bdy_pkg::KIND_FREE, 32'd0, 17'd0, dead_offsets[0]);
    while (live_offsets.size() > 0) release_live(live_offsets.size() - 1);
    repeat (RANDOM_ITEMS) random_item();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || awaited_results.size() > 0 || in_bus.valid)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("buddy_allocator verification clean");
    else $display("buddy_allocator verification failed");
    $finish;
  end

  // Request driver.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_bus.valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        request_t rq;
        rq = pending_reqs.pop_front();
        in_bus.kind <= rq.kind;
        in_bus.req_size <= rq.req_size;
        in_bus.alignment <= rq.alignment;
        in_bus.free_offset <= rq.free_offset;
        in_bus.valid <= 1'b1;
        if ($urandom_range(0, 99) == 0) burst = !burst;
        send_gap = burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls.
  int recv_wait = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) recv_wait = burst ? 0 : $urandom_range(0, 6);
      if (recv_wait > 0) begin
        recv_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    in_took <= rst_n && in_bus.valid && in_bus.ready;
    out_took <= rst_n && out_bus.valid && out_bus.ready;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_results.size() == 0) begin
        report("unexpected result beats", 1, 0);
      end else begin
        outcome_t e;
        e = awaited_results.pop_front();
        if (out_bus.status !== e.status) report("status", out_bus.status, e.status);
        if (out_bus.user_offset !== e.user_offset)
          report("user_offset", out_bus.user_offset, e.user_offset);
        if (out_bus.block_offset !== e.block_offset)
          report("block_offset", out_bus.block_offset, e.block_offset);
        if (out_bus.block_order !== e.block_order)
          report("block_order", out_bus.block_order, e.block_order);
        if (out_bus.bytes_in_use !== e.bytes_in_use)
          report("bytes_in_use", out_bus.bytes_in_use, e.bytes_in_use);
        if (out_bus.free_bytes !== e.free_bytes)
          report("free_bytes", out_bus.free_bytes, e.free_bytes);
      end
    end
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("buddy_allocator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
